>>> rtl/core/ofe_pkg.sv
// Shared types, constants and helpers for the 3D One Euro filter
package ofe_pkg;

	localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
	localparam logic [31:0] CUTOFF_FLOOR = 32'd7;

	localparam logic [7:0] REG_MIN_CUTOFF   = 8'd0;
	localparam logic [7:0] REG_SPEED_GAIN   = 8'd1;
	localparam logic [7:0] REG_DERIV_CUTOFF = 8'd2;
	localparam logic [7:0] REG_TICK_RATE    = 8'd3;

	localparam logic [3:0] LS_IDLE  = 4'd0;
	localparam logic [3:0] LS_RESET = 4'd1;
	localparam logic [3:0] LS_RAW   = 4'd2;
	localparam logic [3:0] LS_DERR  = 4'd3;
	localparam logic [3:0] LS_PERR  = 4'd4;
	localparam logic [3:0] LS_SCALE = 4'd5;
	localparam logic [3:0] LS_ROUND = 4'd6;
	localparam logic [3:0] LS_DUPD  = 4'd7;
	localparam logic [3:0] LS_SQ    = 4'd8;
	localparam logic [3:0] LS_PUPD  = 4'd9;
	localparam logic [3:0] LS_VEL   = 4'd10;

	typedef struct packed {
		logic [3:0]  step;
		logic [4:0]  shift;
		logic [29:0] alpha;
		logic [15:0] rate;
	} lane_ctl_t;

	function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
		logic signed [51:0] hi;
		logic signed [51:0] lo;
		hi = 52'sh0_7FFF_FFFF_FFFF;
		lo = 52'shF_8000_0000_0000;
		if (v > hi) begin
			return 48'sh7FFF_FFFF_FFFF;
		end else if (v < lo) begin
			return 48'sh8000_0000_0000;
		end
		return v[47:0];
	endfunction

endpackage

>>> rtl/core/ofe_if.sv
// Channel interfaces: samples in, results out, register writes
interface ofe_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] target_z;
	modport source(output valid, op, target_x, target_y, target_z, input ready);
	modport sink(input valid, op, target_x, target_y, target_z, output ready);
endinterface

interface ofe_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [47:0] vel_x;
	logic signed [47:0] vel_y;
	logic signed [47:0] vel_z;
	modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface ofe_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/ofe_alpha.sv
// Shared alpha unit: 2*pi*f in Q29, then 30-step restoring division
module ofe_alpha (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] fc,
	input  logic [15:0] rate,
	output logic        done,
	output logic [29:0] alpha
);
	import ofe_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_INIT = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	logic [1:0]  ph_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [47:0] w_q;
	logic [15:0] rate_q;
	logic [48:0] den_q;
	logic [49:0] rem_q;
	logic [29:0] quo_q;
	logic [63:0] prod;
	logic [49:0] rem2;

	assign prod  = 64'(fc) * 64'(TWO_PI_Q29);
	assign rem2  = {rem_q[48:0], 1'b0};
	assign done  = done_q;
	assign alpha = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_DIV) && (cnt_q == 5'd29);
			unique case (ph_q)
				PH_IDLE: if (start) ph_q <= PH_INIT;
				PH_INIT: begin
					ph_q  <= PH_DIV;
					cnt_q <= '0;
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd29) ph_q <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			w_q    <= prod[63:16];
			rate_q <= rate;
		end
		if (ph_q == PH_INIT) begin
			rem_q <= 50'(w_q);
			den_q <= 49'(w_q) + {4'd0, rate_q, 29'd0};
			quo_q <= '0;
		end
		if (ph_q == PH_DIV) begin
			if (rem2 >= 50'(den_q)) begin
				rem_q <= rem2 - 50'(den_q);
				quo_q <= {quo_q[28:0], 1'b1};
			end else begin
				rem_q <= rem2;
				quo_q <= {quo_q[28:0], 1'b0};
			end
		end
	end

endmodule

>>> rtl/core/ofe_isqrt.sv
// Integer square root of a 64-bit sum, one result bit per step
module ofe_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	import ofe_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 5'd31);
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start) begin
				n_q   <= radicand;
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
		end else begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

>>> rtl/core/ofe_lane.sv
// One axis lane: derivative and position state with its own scaling datapath
module ofe_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ofe_pkg::lane_ctl_t        ctl,
	input  logic signed [31:0]        tgt,
	output logic signed [31:0]        pos,
	output logic signed [47:0]        vel,
	output logic [47:0]               mag,
	output logic [61:0]               sq
);
	import ofe_pkg::*;

	logic signed [31:0] prev_q;
	logic signed [31:0] smooth_q;
	logic signed [47:0] de_q;
	logic signed [47:0] raw_q;
	logic signed [48:0] err_q;
	logic               neg_q;
	logic [46:0]        phi_q;
	logic [61:0]        plo_q;
	logic signed [50:0] res_q;
	logic signed [47:0] vel_q;
	logic [61:0]        sq_q;

	logic signed [32:0] d_prev;
	logic signed [32:0] d_pos;
	logic signed [16:0] rate_s;
	logic signed [49:0] raw_p;
	logic signed [49:0] vel_p;
	logic [48:0]        err_mag;
	logic [49:0]        rnd;
	logic signed [50:0] sres;
	logic signed [51:0] de_sum;
	logic [30:0]        sh;

	assign d_prev  = 33'(tgt) - 33'(prev_q);
	assign d_pos   = 33'(tgt) - 33'(smooth_q);
	assign rate_s  = $signed({1'b0, ctl.rate});
	assign raw_p   = 50'(d_prev) * 50'(rate_s);
	assign vel_p   = 50'($signed(res_q[32:0])) * 50'(rate_s);
	assign err_mag = err_q[48] ? 49'(-err_q) : 49'(err_q);
	assign rnd     = {1'b0, phi_q, 2'b00} + 50'((plo_q + 62'h2000_0000) >> 30);
	assign sres    = neg_q ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
	assign de_sum  = 52'(de_q) + 52'(res_q);
	assign mag     = de_q[47] ? 48'(-de_q) : 48'(de_q);
	assign sh      = 31'(mag >> ctl.shift);
	assign pos     = smooth_q;
	assign vel     = vel_q;
	assign sq      = sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			smooth_q <= '0;
			de_q     <= '0;
		end else begin
			unique case (ctl.step)
				LS_RESET: begin
					prev_q   <= tgt;
					smooth_q <= tgt;
					de_q     <= '0;
				end
				LS_DUPD: de_q <= sat48(de_sum);
				LS_PUPD: smooth_q <= smooth_q + res_q[31:0];
				LS_VEL:  prev_q <= tgt;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.step)
			LS_RAW:  raw_q <= sat48(52'(raw_p));
			LS_DERR: err_q <= 49'(raw_q) - 49'(de_q);
			LS_PERR: err_q <= 49'(d_pos);
			LS_SCALE: begin
				neg_q <= err_q[48];
				phi_q <= 47'(err_mag[48:32]) * 47'(ctl.alpha);
				plo_q <= 62'(err_mag[31:0]) * 62'(ctl.alpha);
			end
			LS_ROUND: res_q <= sres;
			LS_SQ:    sq_q <= 62'(sh) * 62'(sh);
			LS_VEL:   vel_q <= sat48(52'(vel_p));
			default: ;
		endcase
	end

endmodule

>>> rtl/core/one_euro_filter_3d.sv
// Top level of the 3D One Euro filter: sequencer, shared units and lane merge
// A sample item goes from transfer to a valid result through two alpha
// evaluations (start, one multiply, then a 30-step restoring division in the
// shared alpha unit) and a square root for the speed, in series, plus lane
// arithmetic and sequencing. A reset item gives no result. One item is in
// flight at a time; a finished result waits in the output register while the
// next item is taken in.
// Registers may be written at any time the block is idle; indexes beyond
// three are ignored.
module one_euro_filter_3d (
	input logic clk,
	input logic arst_n,
	ofe_cfg_if.sink cfg,
	ofe_in_if.sink  sample,
	ofe_out_if.source result
);
	import ofe_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RST  = 5'd1;
	localparam logic [4:0] S_AD   = 5'd2;
	localparam logic [4:0] S_ADW  = 5'd3;
	localparam logic [4:0] S_DERR = 5'd4;
	localparam logic [4:0] S_DSC  = 5'd5;
	localparam logic [4:0] S_DRND = 5'd6;
	localparam logic [4:0] S_DUPD = 5'd7;
	localparam logic [4:0] S_MAG  = 5'd8;
	localparam logic [4:0] S_SQ   = 5'd9;
	localparam logic [4:0] S_SUM  = 5'd10;
	localparam logic [4:0] S_SQS  = 5'd11;
	localparam logic [4:0] S_SQW  = 5'd12;
	localparam logic [4:0] S_FCM  = 5'd13;
	localparam logic [4:0] S_FCA  = 5'd14;
	localparam logic [4:0] S_AP   = 5'd15;
	localparam logic [4:0] S_APW  = 5'd16;
	localparam logic [4:0] S_PERR = 5'd17;
	localparam logic [4:0] S_PSC  = 5'd18;
	localparam logic [4:0] S_PRND = 5'd19;
	localparam logic [4:0] S_PUPD = 5'd20;
	localparam logic [4:0] S_VEL  = 5'd21;
	localparam logic [4:0] S_OUT  = 5'd22;

	logic [4:0]  st_q;
	logic [31:0] mfc_q;
	logic [31:0] sg_q;
	logic [31:0] dfc_q;
	logic [15:0] rate_q;

	logic signed [31:0] tgt_q [3];
	logic [29:0] a_q;
	logic [4:0]  s_q;
	logic [63:0] sum_q;
	logic [48:0] len_q;
	logic [48:0] fph_q;
	logic [63:0] fpl_q;
	logic [31:0] fc_q;

	logic               out_valid_q;
	logic signed [31:0] opos_q [3];
	logic signed [47:0] ovel_q [3];

	logic signed [31:0] l_pos [3];
	logic signed [47:0] l_vel [3];
	logic [47:0]        l_mag [3];
	logic [61:0]        l_sq  [3];

	lane_ctl_t   ctl;
	logic [15:0] rate_eff;
	logic [31:0] mfc_eff;
	logic [31:0] dfc_eff;
	logic        a_start;
	logic [31:0] a_f;
	logic        a_done;
	logic [29:0] a_res;
	logic        r_done;
	logic [31:0] r_root;
	logic [47:0] or_m;
	logic [4:0]  shift_c;
	logic [49:0] fc_sum;
	logic        take;
	logic        emit;

	assign rate_eff = (rate_q == 16'd0) ? 16'd1 : rate_q;
	assign mfc_eff  = (mfc_q < CUTOFF_FLOOR) ? CUTOFF_FLOOR : mfc_q;
	assign dfc_eff  = (dfc_q < CUTOFF_FLOOR) ? CUTOFF_FLOOR : dfc_q;

	assign sample.ready = (st_q == S_IDLE);
	assign take         = sample.valid && sample.ready;
	assign emit         = (st_q == S_OUT) && (!out_valid_q || result.ready);
	assign cfg.ready    = 1'b1;

	assign a_start = (st_q == S_AD) || (st_q == S_AP);
	assign a_f     = (st_q == S_AP) ? fc_q : dfc_eff;

	always_comb begin
		ctl.shift = s_q;
		ctl.alpha = a_q;
		ctl.rate  = rate_eff;
		case (st_q)
			S_RST:          ctl.step = LS_RESET;
			S_AD:           ctl.step = LS_RAW;
			S_DERR:         ctl.step = LS_DERR;
			S_PERR:         ctl.step = LS_PERR;
			S_DSC, S_PSC:   ctl.step = LS_SCALE;
			S_DRND, S_PRND: ctl.step = LS_ROUND;
			S_DUPD:         ctl.step = LS_DUPD;
			S_SQ:           ctl.step = LS_SQ;
			S_PUPD:         ctl.step = LS_PUPD;
			S_VEL:          ctl.step = LS_VEL;
			default:        ctl.step = LS_IDLE;
		endcase
	end

	always_comb begin
		or_m    = l_mag[0] | l_mag[1] | l_mag[2];
		shift_c = '0;
		for (int i = 0; i < 17; i++) begin
			if (or_m[31 + i]) shift_c = 5'(i + 1);
		end
	end

	assign fc_sum = 50'(mfc_eff) + 50'({fph_q[15:0], 16'd0}) + 50'(fpl_q[63:16]);

	for (genvar g = 0; g < 3; g++) begin : g_lane
		ofe_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.tgt    (tgt_q[g]),
			.pos    (l_pos[g]),
			.vel    (l_vel[g]),
			.mag    (l_mag[g]),
			.sq     (l_sq[g])
		);
	end

	ofe_alpha u_alpha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (a_start),
		.fc     (a_f),
		.rate   (rate_eff),
		.done   (a_done),
		.alpha  (a_res)
	);

	ofe_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (st_q == S_SQS),
		.radicand (sum_q),
		.done     (r_done),
		.root     (r_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mfc_q  <= 32'd65536;
			sg_q   <= '0;
			dfc_q  <= 32'd65536;
			rate_q <= 16'd1000;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MIN_CUTOFF:   mfc_q  <= cfg.data;
				REG_SPEED_GAIN:   sg_q   <= cfg.data;
				REG_DERIV_CUTOFF: dfc_q  <= cfg.data;
				REG_TICK_RATE:    rate_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !(result.valid && result.ready));
			unique case (st_q)
				S_IDLE:  if (take) st_q <= sample.op ? S_RST : S_AD;
				S_RST:   st_q <= S_IDLE;
				S_AD:    st_q <= S_ADW;
				S_ADW:   if (a_done) st_q <= S_DERR;
				S_DERR:  st_q <= S_DSC;
				S_DSC:   st_q <= S_DRND;
				S_DRND:  st_q <= S_DUPD;
				S_DUPD:  st_q <= S_MAG;
				S_MAG:   st_q <= S_SQ;
				S_SQ:    st_q <= S_SUM;
				S_SUM:   st_q <= S_SQS;
				S_SQS:   st_q <= S_SQW;
				S_SQW:   if (r_done) st_q <= S_FCM;
				S_FCM:   st_q <= S_FCA;
				S_FCA:   st_q <= S_AP;
				S_AP:    st_q <= S_APW;
				S_APW:   if (a_done) st_q <= S_PERR;
				S_PERR:  st_q <= S_PSC;
				S_PSC:   st_q <= S_PRND;
				S_PRND:  st_q <= S_PUPD;
				S_PUPD:  st_q <= S_VEL;
				S_VEL:   st_q <= S_OUT;
				S_OUT:   if (emit) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tgt_q[0] <= sample.target_x;
			tgt_q[1] <= sample.target_y;
			tgt_q[2] <= sample.target_z;
		end
		if ((st_q == S_ADW || st_q == S_APW) && a_done) a_q <= a_res;
		if (st_q == S_MAG) s_q <= shift_c;
		if (st_q == S_SUM) sum_q <= 64'(l_sq[0]) + 64'(l_sq[1]) + 64'(l_sq[2]);
		if (st_q == S_SQW && r_done) len_q <= {17'd0, r_root} << s_q;
		if (st_q == S_FCM) begin
			fph_q <= 49'(sg_q) * 49'(len_q[48:32]);
			fpl_q <= 64'(sg_q) * 64'(len_q[31:0]);
		end
		if (st_q == S_FCA) begin
			if (fph_q >= 49'h1_0000 || fc_sum > 50'hFFFF_FFFF) begin
				fc_q <= 32'hFFFF_FFFF;
			end else begin
				fc_q <= fc_sum[31:0];
			end
		end
		if (emit) begin
			for (int i = 0; i < 3; i++) begin
				opos_q[i] <= l_pos[i];
				ovel_q[i] <= l_vel[i];
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.pos_x = opos_q[0];
	assign result.pos_y = opos_q[1];
	assign result.pos_z = opos_q[2];
	assign result.vel_x = ovel_q[0];
	assign result.vel_y = ovel_q[1];
	assign result.vel_z = ovel_q[2];

endmodule
